// ===== hdl/hrlc_pkg.sv =====
`timescale 1ns / 1ps

package hrlc_pkg;

  localparam int BUFFER_BYTES = 128;

  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_DEL      = 8'h7f;
  localparam logic [7:0] CHAR_QUESTION = 8'h3f;
  localparam logic [7:0] CHAR_SLASH    = 8'h2f;

  localparam logic [2:0] GET_LEN      = 3'd3;
  localparam logic [2:0] LOG_LEN      = 3'd4;
  localparam logic [2:0] ROOT_LEN     = 3'd1;
  localparam logic [4:0] QUERY_ON_LEN  = 5'd16;
  localparam logic [4:0] QUERY_OFF_LEN = 5'd9;

  localparam logic [2:0] ROUTE_BAD_REQ    = 3'd0;
  localparam logic [2:0] ROUTE_BAD_METHOD = 3'd1;
  localparam logic [2:0] ROUTE_LED        = 3'd2;
  localparam logic [2:0] ROUTE_LOG        = 3'd3;
  localparam logic [2:0] ROUTE_NOT_FOUND  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic [1:0] conn_id;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] out_conn;
    logic [2:0] route;
    logic       led_on;
  } out_beat_t;

  // "GET"
  function automatic logic [7:0] get_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "/log"
  function automatic logic [7:0] log_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h2f;
      3'd1:    c = 8'h6c;
      3'd2:    c = 8'h6f;
      3'd3:    c = 8'h67;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "ledonoff=&led=on", the off query is its first nine characters
  function automatic logic [7:0] query_char(input logic [4:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = 8'h6c;
      5'd1:    c = 8'h65;
      5'd2:    c = 8'h64;
      5'd3:    c = 8'h6f;
      5'd4:    c = 8'h6e;
      5'd5:    c = 8'h6f;
      5'd6:    c = 8'h66;
      5'd7:    c = 8'h66;
      5'd8:    c = 8'h3d;
      5'd9:    c = 8'h26;
      5'd10:   c = 8'h6c;
      5'd11:   c = 8'h65;
      5'd12:   c = 8'h64;
      5'd13:   c = 8'h3d;
      5'd14:   c = 8'h6f;
      5'd15:   c = 8'h6e;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/http_request_line_classifier_core.sv =====
`timescale 1ns / 1ps

// http request line classifier
// in channel: one request byte per beat (in_valid / in_ready / in_data), with a
//   first flag that restarts parsing, a last flag for the end of the receive
//   buffer and the connection id (sampled on a first byte only)
// out channel: one classification beat per finished request (out_conn, route,
//   led_on), where led_on is the led flag after the request was applied
// cfg channel: writes the 4-bit reserved mask, always ready; the user must
//   write it only while the block is idle, the block does not enforce this
// throughput: one byte per cycle unless stalled; the per-byte match update is
//   one level of small compares between parse state registers and result stage
// result: the beat that ends the request (closing space, bad byte, last flag
//   or buffer limit) loads it into the output or skid register
// stall: a two-entry output buffer (output register plus skid register) lets
//   the block keep taking bytes while one result waits; in_ready drops only
//   when both entries hold results
// reset: synchronous, clears the parse phase to idle, the led flag, the
//   reserved mask and both output entries
module http_request_line_classifier_core
  import hrlc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [3:0] cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEAD,
    PH_METHOD,
    PH_GAP,
    PH_PATH
  } phase_t;

  // parse state
  phase_t     phase, phase_next;
  logic [7:0] byte_count, byte_count_next;
  logic [2:0] method_pos, method_pos_next;
  logic       method_ok, method_ok_next;
  logic [2:0] path_pos, path_pos_next;
  logic       path_root_ok, path_root_ok_next;
  logic       path_log_ok, path_log_ok_next;
  logic       query_seen, query_seen_next;
  logic [4:0] query_pos, query_pos_next;
  logic       query_on_ok, query_on_ok_next;
  logic       query_off_ok, query_off_ok_next;
  logic [1:0] current_conn, current_conn_next;
  logic       led_flag, led_flag_next;
  logic [3:0] reserved_mask;

  // output buffer
  out_beat_t  skid_data;
  logic       skid_valid;

  logic       in_fire, out_fire;
  logic       finished;
  logic [2:0] route;
  out_beat_t  result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    logic [7:0] b;
    logic       is_end;
    logic       is_root;
    logic       is_log;

    b = in_data.data_byte;
    phase_next        = phase;
    byte_count_next   = byte_count;
    method_pos_next   = method_pos;
    method_ok_next    = method_ok;
    path_pos_next     = path_pos;
    path_root_ok_next = path_root_ok;
    path_log_ok_next  = path_log_ok;
    query_seen_next   = query_seen;
    query_pos_next    = query_pos;
    query_on_ok_next  = query_on_ok;
    query_off_ok_next = query_off_ok;
    current_conn_next = current_conn;
    led_flag_next     = led_flag;
    finished = 1'b0;
    route    = ROUTE_BAD_REQ;
    is_end   = 1'b0;
    is_root  = 1'b0;
    is_log   = 1'b0;

    // a first byte restarts the parse; a reserved connection goes idle
    if (in_data.first) begin
      current_conn_next = in_data.conn_id;
      byte_count_next   = 8'd0;
      method_pos_next   = 3'd0;
      method_ok_next    = 1'b1;
      path_pos_next     = 3'd0;
      path_root_ok_next = 1'b1;
      path_log_ok_next  = 1'b1;
      query_seen_next   = 1'b0;
      query_pos_next    = 5'd0;
      query_on_ok_next  = 1'b0;
      query_off_ok_next = 1'b0;
      phase_next = reserved_mask[in_data.conn_id] ? PH_DONE : PH_LEAD;
    end

    if (phase_next != PH_DONE) begin
      is_end = in_data.last || (byte_count_next >= 8'(BUFFER_BYTES - 1));
      if (byte_count_next != 8'hff) begin
        byte_count_next = byte_count_next + 8'd1;
      end

      if (b < CHAR_SPACE || b >= CHAR_DEL) begin
        finished = 1'b1;
        route    = ROUTE_BAD_REQ;
      end else begin
        case (phase_next)
          PH_LEAD, PH_METHOD: begin
            if (b == CHAR_SPACE) begin
              if (phase_next == PH_METHOD) begin
                phase_next = PH_GAP;
              end
            end else begin
              method_ok_next = method_ok_next && (method_pos_next < GET_LEN)
                               && (b == get_char(method_pos_next));
              if (method_pos_next < GET_LEN + 3'd1) begin
                method_pos_next = method_pos_next + 3'd1;
              end
              phase_next = PH_METHOD;
            end
          end
          PH_GAP, PH_PATH: begin
            if (b == CHAR_SPACE && phase_next == PH_PATH) begin
              // closing space: classify the request
              finished = 1'b1;
              if (!(method_ok_next && method_pos_next == GET_LEN)) begin
                route = ROUTE_BAD_METHOD;
              end else begin
                if (query_seen_next) begin
                  is_root = path_root_ok_next;
                  is_log  = path_log_ok_next;
                end else begin
                  is_root = path_root_ok_next && path_pos_next == ROOT_LEN;
                  is_log  = path_log_ok_next && path_pos_next == LOG_LEN;
                end
                if (is_root) begin
                  route = ROUTE_LED;
                  if (query_seen_next) begin
                    if (query_on_ok_next && query_pos_next == QUERY_ON_LEN) begin
                      led_flag_next = 1'b1;
                    end
                    if (query_off_ok_next && query_pos_next == QUERY_OFF_LEN) begin
                      led_flag_next = 1'b0;
                    end
                  end
                end else if (is_log) begin
                  route = ROUTE_LOG;
                end else begin
                  route = ROUTE_NOT_FOUND;
                end
              end
            end else if (b != CHAR_SPACE) begin
              phase_next = PH_PATH;
              if (b == CHAR_QUESTION) begin
                // the last '?' starts the query; a second one spoils the path
                if (query_seen_next) begin
                  path_root_ok_next = 1'b0;
                  path_log_ok_next  = 1'b0;
                end else begin
                  path_root_ok_next = path_root_ok_next && path_pos_next == ROOT_LEN;
                  path_log_ok_next  = path_log_ok_next && path_pos_next == LOG_LEN;
                end
                query_seen_next   = 1'b1;
                query_pos_next    = 5'd0;
                query_on_ok_next  = 1'b1;
                query_off_ok_next = 1'b1;
              end else if (query_seen_next) begin
                query_on_ok_next = query_on_ok_next && (query_pos_next < QUERY_ON_LEN)
                                   && (b == query_char(query_pos_next));
                query_off_ok_next = query_off_ok_next && (query_pos_next < QUERY_OFF_LEN)
                                    && (b == query_char(query_pos_next));
                if (query_pos_next < QUERY_ON_LEN + 5'd1) begin
                  query_pos_next = query_pos_next + 5'd1;
                end
              end else begin
                path_root_ok_next = path_root_ok_next && (path_pos_next < ROOT_LEN)
                                    && (b == CHAR_SLASH);
                path_log_ok_next = path_log_ok_next && (path_pos_next < LOG_LEN)
                                   && (b == log_char(path_pos_next));
                if (path_pos_next < LOG_LEN + 3'd1) begin
                  path_pos_next = path_pos_next + 3'd1;
                end
              end
            end
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
      end

      // buffer ran out before the closing space
      if (!finished && is_end) begin
        finished = 1'b1;
        route    = ROUTE_BAD_REQ;
      end
      if (finished) begin
        phase_next = PH_DONE;
      end
    end

    result.out_conn = current_conn_next;
    result.route    = route;
    result.led_on   = led_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DONE;
      led_flag      <= 1'b0;
      reserved_mask <= 4'd0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reserved_mask <= cfg_data;
      end

      if (in_fire) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        method_pos   <= method_pos_next;
        method_ok    <= method_ok_next;
        path_pos     <= path_pos_next;
        path_root_ok <= path_root_ok_next;
        path_log_ok  <= path_log_ok_next;
        query_seen   <= query_seen_next;
        query_pos    <= query_pos_next;
        query_on_ok  <= query_on_ok_next;
        query_off_ok <= query_off_ok_next;
        current_conn <= current_conn_next;
        led_flag     <= led_flag_next;
      end

      // two-entry output buffer, skid drains first
      if (skid_valid) begin
        if (out_fire) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (!out_valid || out_fire) begin
        out_valid <= in_fire && finished;
        if (in_fire && finished) begin
          out_data <= result;
        end
      end else if (in_fire && finished) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule
